@@ rtl/qrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared widths, codes and item types for the solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 32;
    localparam int THR_W     = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd66;

    localparam int PROD_W   = 2 * COEF_W;
    localparam int DISC_W   = PROD_W + 2;
    localparam int ROOT_W   = DISC_W / 2;
    localparam int SREM_W   = ROOT_W + 2;
    localparam int SQ_STEPS = ROOT_W;
    localparam int NB_W     = COEF_W + 1;
    localparam int DEN_W    = COEF_W + 2;
    localparam int DMAG_W   = DEN_W - 1;
    localparam int NUMS_W   = ROOT_W + 2;
    localparam int NMAG_W   = NUMS_W - 1;
    localparam int DIVN_W   = NMAG_W + FRAC_BITS;

    localparam logic [DIVN_W-1:0] QNEG_LIM =
        {{(DIVN_W-COEF_W){1'b0}}, 1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [DIVN_W-1:0] QPOS_LIM = QNEG_LIM - 1'b1;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_TWO  = 2'd2;
    localparam logic [1:0] KIND_INF  = 2'd3;

    typedef enum logic [2:0] {
        MODE_NONE = 3'd0,
        MODE_INF  = 3'd1,
        MODE_LIN  = 3'd2,
        MODE_ONE  = 3'd3,
        MODE_TWO  = 3'd4
    } mode_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coeff_a;
        logic signed [COEF_W-1:0] coeff_b;
        logic signed [COEF_W-1:0] coeff_c;
    } qrs_in_t;

    typedef struct packed {
        logic [1:0]               root_kind;
        logic signed [COEF_W-1:0] root_one;
        logic signed [COEF_W-1:0] root_two;
        logic                     root_overflow;
    } qrs_out_t;

    typedef struct packed {
        mode_t             mode;
        logic [NB_W-1:0]   nb;
        logic [DEN_W-1:0]  den;
    } sq_meta_t;

    typedef struct packed {
        mode_t mode;
        logic  neg_one;
        logic  neg_two;
    } div_meta_t;

endpackage

@@ rtl/quadratic_root_solver_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver core
// Solves a*x^2 + b*x + c = 0 on signed Q16.16 coefficients, fully pipelined.
// ----------------------------------------------------------------------------
// One equation enters per clock while not held; its roots cross four front-end
// stages (capture, 32x32 products, discriminant, case select), one stage per
// bit of the 33-bit square root, one input stage plus one stage per
// quotient bit of the 50-bit two-lane divider, and the output register. The
// whole pipeline holds while a result waits on root_stall; cfg_ready is always
// high and the threshold should be written only while the pipeline is empty.
module quadratic_root_solver_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           eq_valid,
    output logic                           eq_stall,
    input  qrs_pkg::qrs_in_t               eq_data,
    output logic                           root_valid,
    input  logic                           root_stall,
    output qrs_pkg::qrs_out_t              root_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qrs_pkg::THR_W-1:0]      cfg_data
);
    import qrs_pkg::*;

    function automatic logic [COEF_W:0] saturate(logic [DIVN_W-1:0] q, logic neg);
        logic [COEF_W-1:0] low;
        low = q[COEF_W-1:0];
        if (!neg)
        begin
            return (q > QPOS_LIM) ? {1'b1, 1'b0, {(COEF_W-1){1'b1}}} : {1'b0, low};
        end
        return (q > QNEG_LIM) ? {1'b1, 1'b1, {(COEF_W-1){1'b0}}} : {1'b0, ~low + 1'b1};
    endfunction

    logic [THR_W-1:0]  thr_reg;
    logic              en;

    logic              fr_valid;
    sq_meta_t          fr_meta;
    logic [DISC_W-1:0] fr_x;

    logic              sq_valid;
    sq_meta_t          sq_meta;
    logic [ROOT_W-1:0] sq_root;

    logic [NUMS_W-1:0] nb_ext;
    logic [NUMS_W-1:0] s_add;
    logic [NUMS_W-1:0] num_one;
    logic [NUMS_W-1:0] num_two;
    logic [NUMS_W-1:0] mag_one;
    logic [NUMS_W-1:0] mag_two;
    logic [DEN_W-1:0]  den_abs;
    div_meta_t         dv_meta_in;

    logic              dv_valid;
    div_meta_t         dv_meta;
    logic [DIVN_W-1:0] dv_q_one;
    logic [DIVN_W-1:0] dv_q_two;

    logic [COEF_W:0]   sat_one;
    logic [COEF_W:0]   sat_two;

    logic              root_valid_reg;
    qrs_out_t          root_data_reg;
    qrs_out_t          root_data_next;

    assign en        = !root_valid_reg || !root_stall;
    assign eq_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .thr       (thr_reg),
        .in_valid  (eq_valid),
        .in_data   (eq_data),
        .out_valid (fr_valid),
        .out_meta  (fr_meta),
        .out_x     (fr_x)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_meta   (fr_meta),
        .in_x      (fr_x),
        .out_valid (sq_valid),
        .out_meta  (sq_meta),
        .out_root  (sq_root)
    );

    assign nb_ext  = {{(NUMS_W-NB_W){sq_meta.nb[NB_W-1]}}, sq_meta.nb};
    assign s_add   = (sq_meta.mode == MODE_TWO) ?
                     {{(NUMS_W-ROOT_W){1'b0}}, sq_root} : '0;
    assign num_one = nb_ext + s_add;
    assign num_two = nb_ext - s_add;
    assign mag_one = num_one[NUMS_W-1] ? (~num_one + 1'b1) : num_one;
    assign mag_two = num_two[NUMS_W-1] ? (~num_two + 1'b1) : num_two;
    assign den_abs = sq_meta.den[DEN_W-1] ? (~sq_meta.den + 1'b1) : sq_meta.den;

    assign dv_meta_in.mode    = sq_meta.mode;
    assign dv_meta_in.neg_one = num_one[NUMS_W-1] ^ sq_meta.den[DEN_W-1];
    assign dv_meta_in.neg_two = num_two[NUMS_W-1] ^ sq_meta.den[DEN_W-1];

    qrs_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sq_valid),
        .in_meta    (dv_meta_in),
        .in_num_one ({mag_one[NMAG_W-1:0], {FRAC_BITS{1'b0}}}),
        .in_num_two ({mag_two[NMAG_W-1:0], {FRAC_BITS{1'b0}}}),
        .in_den     (den_abs[DMAG_W-1:0]),
        .out_valid  (dv_valid),
        .out_meta   (dv_meta),
        .out_q_one  (dv_q_one),
        .out_q_two  (dv_q_two)
    );

    assign sat_one = saturate(dv_q_one, dv_meta.neg_one);
    assign sat_two = saturate(dv_q_two, dv_meta.neg_two);

    always_comb
    begin
        root_data_next = '0;
        unique case (dv_meta.mode)
            MODE_NONE:
            begin
                root_data_next.root_kind = KIND_NONE;
            end
            MODE_INF:
            begin
                root_data_next.root_kind = KIND_INF;
            end
            MODE_LIN:
            begin
                root_data_next.root_kind     = KIND_ONE;
                root_data_next.root_one      = sat_one[COEF_W-1:0];
                root_data_next.root_overflow = sat_one[COEF_W];
            end
            MODE_ONE:
            begin
                root_data_next.root_kind     = KIND_ONE;
                root_data_next.root_one      = sat_one[COEF_W-1:0];
                root_data_next.root_two      = sat_one[COEF_W-1:0];
                root_data_next.root_overflow = sat_one[COEF_W];
            end
            MODE_TWO:
            begin
                root_data_next.root_kind     = KIND_TWO;
                root_data_next.root_one      = sat_one[COEF_W-1:0];
                root_data_next.root_two      = sat_two[COEF_W-1:0];
                root_data_next.root_overflow = sat_one[COEF_W] | sat_two[COEF_W];
            end
            default:
            begin
                root_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            root_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_data_reg <= root_data_next;
        end
    end

    assign root_valid = root_valid_reg;
    assign root_data  = root_data_reg;

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_data.root_kind == KIND_NONE |->
        root_data.root_one == '0 && root_data.root_two == '0 && !root_data.root_overflow)
        else $error("no-root item carries root data");

    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_data.root_kind == KIND_INF |->
        root_data.root_one == '0 && root_data.root_two == '0 && !root_data.root_overflow)
        else $error("infinite-root item carries root data");

    a_one_pair: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_data.root_kind == KIND_ONE && root_data.root_two != '0 |->
        root_data.root_two == root_data.root_one)
        else $error("single root item with mismatched second root");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> thr_reg == $past(cfg_data))
        else $error("threshold write lost");

endmodule

@@ rtl/qrs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver front end
// Input capture, products, discriminant and case selection in four stages.
// ----------------------------------------------------------------------------
module qrs_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic [qrs_pkg::THR_W-1:0]      thr,
    input  logic                           in_valid,
    input  qrs_pkg::qrs_in_t               in_data,
    output logic                           out_valid,
    output qrs_pkg::sq_meta_t              out_meta,
    output logic [qrs_pkg::DISC_W-1:0]     out_x
);
    import qrs_pkg::*;

    function automatic logic near_zero(logic [COEF_W-1:0] v, logic [THR_W-1:0] t);
        logic [COEF_W:0] ext;
        logic [COEF_W:0] mag;
        ext = {v[COEF_W-1], v};
        mag = ext[COEF_W] ? (~ext + 1'b1) : ext;
        return (v == '0) || (mag < {{(COEF_W+1-THR_W){1'b0}}, t});
    endfunction

    logic                     s1_vld_reg;
    qrs_in_t                  s1_data_reg;

    logic                     s2_vld_reg;
    logic [PROD_W-1:0]        s2_bb_reg;
    logic [PROD_W-1:0]        s2_ac_reg;
    qrs_in_t                  s2_data_reg;
    logic [2:0]               s2_nz_reg;
    logic signed [PROD_W-1:0] bb_next;
    logic signed [PROD_W-1:0] ac_next;
    logic [2:0]               nz_next;

    logic                     s3_vld_reg;
    logic [DISC_W-1:0]        s3_d_reg;
    qrs_in_t                  s3_data_reg;
    logic [2:0]               s3_nz_reg;
    logic [DISC_W-1:0]        d_next;

    logic                     s4_vld_reg;
    sq_meta_t                 s4_meta_reg;
    logic [DISC_W-1:0]        s4_x_reg;
    sq_meta_t                 meta_next;
    logic [DISC_W-1:0]        x_next;
    logic [DISC_W-1:0]        dmag;
    logic                     dzero;

    assign bb_next = s1_data_reg.coeff_b * s1_data_reg.coeff_b;
    assign ac_next = s1_data_reg.coeff_a * s1_data_reg.coeff_c;
    assign nz_next = {near_zero(s1_data_reg.coeff_a, thr),
                      near_zero(s1_data_reg.coeff_b, thr),
                      near_zero(s1_data_reg.coeff_c, thr)};

    assign d_next = {{2{s2_bb_reg[PROD_W-1]}}, s2_bb_reg} - {s2_ac_reg, 2'b00};

    assign dmag  = s3_d_reg[DISC_W-1] ? (~s3_d_reg + 1'b1) : s3_d_reg;
    assign dzero = (s3_d_reg == '0) ||
                   (dmag < {{(DISC_W-THR_W-FRAC_BITS){1'b0}}, thr, {FRAC_BITS{1'b0}}});

    always_comb
    begin
        meta_next.mode = MODE_NONE;
        if (s3_nz_reg[2])
        begin
            if (s3_nz_reg[1])
            begin
                meta_next.mode = s3_nz_reg[0] ? MODE_INF : MODE_NONE;
            end
            else
            begin
                meta_next.mode = MODE_LIN;
            end
        end
        else if (dzero)
        begin
            meta_next.mode = MODE_ONE;
        end
        else if (s3_d_reg[DISC_W-1])
        begin
            meta_next.mode = MODE_NONE;
        end
        else
        begin
            meta_next.mode = MODE_TWO;
        end

        if (meta_next.mode == MODE_LIN)
        begin
            meta_next.nb  = ~{s3_data_reg.coeff_c[COEF_W-1], s3_data_reg.coeff_c} + 1'b1;
            meta_next.den = {{2{s3_data_reg.coeff_b[COEF_W-1]}}, s3_data_reg.coeff_b};
        end
        else
        begin
            meta_next.nb  = ~{s3_data_reg.coeff_b[COEF_W-1], s3_data_reg.coeff_b} + 1'b1;
            meta_next.den = {s3_data_reg.coeff_a[COEF_W-1], s3_data_reg.coeff_a, 1'b0};
        end
        x_next = (meta_next.mode == MODE_TWO) ? s3_d_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_data_reg <= in_data;
            s2_bb_reg   <= bb_next;
            s2_ac_reg   <= ac_next;
            s2_data_reg <= s1_data_reg;
            s2_nz_reg   <= nz_next;
            s3_d_reg    <= d_next;
            s3_data_reg <= s2_data_reg;
            s3_nz_reg   <= s2_nz_reg;
            s4_meta_reg <= meta_next;
            s4_x_reg    <= x_next;
        end
    end

    assign out_valid = s4_vld_reg;
    assign out_meta  = s4_meta_reg;
    assign out_x     = s4_x_reg;

endmodule

@@ rtl/qrs_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver square root
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  qrs_pkg::sq_meta_t              in_meta,
    input  logic [qrs_pkg::DISC_W-1:0]     in_x,
    output logic                           out_valid,
    output qrs_pkg::sq_meta_t              out_meta,
    output logic [qrs_pkg::ROOT_W-1:0]     out_root
);
    import qrs_pkg::*;

    logic [SQ_STEPS-1:0] vld_reg;
    logic [SQ_STEPS-1:0] vld_next;
    logic [DISC_W-1:0]   x_reg    [SQ_STEPS];
    logic [DISC_W-1:0]   x_next   [SQ_STEPS];
    logic [SREM_W-1:0]   rem_reg  [SQ_STEPS];
    logic [SREM_W-1:0]   rem_next [SQ_STEPS];
    logic [ROOT_W-1:0]   root_reg [SQ_STEPS];
    logic [ROOT_W-1:0]   root_next[SQ_STEPS];
    sq_meta_t            meta_reg [SQ_STEPS];
    sq_meta_t            meta_next[SQ_STEPS];

    always_comb
    begin
        logic [DISC_W-1:0] xs;
        logic [SREM_W-1:0] rs;
        logic [SREM_W-1:0] rt;
        logic [SREM_W-1:0] trial;
        logic [ROOT_W-1:0] qs;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                xs           = in_x;
                rs           = '0;
                qs           = '0;
                vld_next[k]  = in_valid;
                meta_next[k] = in_meta;
            end
            else
            begin
                xs           = x_reg[k-1];
                rs           = rem_reg[k-1];
                qs           = root_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
                meta_next[k] = meta_reg[k-1];
            end
            rt    = {rs[SREM_W-3:0], xs[DISC_W-1 -: 2]};
            trial = {qs, 2'b01};
            if (rt >= trial)
            begin
                rem_next[k]  = rt - trial;
                root_next[k] = {qs[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rt;
                root_next[k] = {qs[ROOT_W-2:0], 1'b0};
            end
            x_next[k] = {xs[DISC_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            meta_reg <= meta_next;
        end
    end

    assign out_valid = vld_reg[SQ_STEPS-1];
    assign out_meta  = meta_reg[SQ_STEPS-1];
    assign out_root  = root_reg[SQ_STEPS-1];

endmodule

@@ rtl/qrs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver divider
// Two-lane pipelined restoring divider over magnitudes, shared divisor.
// ----------------------------------------------------------------------------
module qrs_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  qrs_pkg::div_meta_t             in_meta,
    input  logic [qrs_pkg::DIVN_W-1:0]     in_num_one,
    input  logic [qrs_pkg::DIVN_W-1:0]     in_num_two,
    input  logic [qrs_pkg::DMAG_W-1:0]     in_den,
    output logic                           out_valid,
    output qrs_pkg::div_meta_t             out_meta,
    output logic [qrs_pkg::DIVN_W-1:0]     out_q_one,
    output logic [qrs_pkg::DIVN_W-1:0]     out_q_two
);
    import qrs_pkg::*;

    function automatic logic [DMAG_W+DIVN_W-1:0] div_step(
        logic [DMAG_W-1:0] rem, logic [DIVN_W-1:0] nq, logic [DMAG_W-1:0] den);
        logic [DMAG_W:0] rt;
        logic [DMAG_W:0] diff;
        logic            ge;
        rt   = {rem, nq[DIVN_W-1]};
        diff = rt - {1'b0, den};
        ge   = (rt >= {1'b0, den});
        return {ge ? diff[DMAG_W-1:0] : rt[DMAG_W-1:0], nq[DIVN_W-2:0], ge};
    endfunction

    logic              in_vld_reg;
    div_meta_t         in_meta_reg;
    logic [DIVN_W-1:0] in_n1_reg;
    logic [DIVN_W-1:0] in_n2_reg;
    logic [DMAG_W-1:0] in_den_reg;

    logic [DIVN_W-1:0] vld_reg;
    logic [DIVN_W-1:0] vld_next;
    div_meta_t         meta_reg [DIVN_W];
    div_meta_t         meta_next[DIVN_W];
    logic [DMAG_W-1:0] den_reg  [DIVN_W];
    logic [DMAG_W-1:0] den_next [DIVN_W];
    logic [DMAG_W-1:0] r1_reg   [DIVN_W];
    logic [DMAG_W-1:0] r1_next  [DIVN_W];
    logic [DIVN_W-1:0] n1_reg   [DIVN_W];
    logic [DIVN_W-1:0] n1_next  [DIVN_W];
    logic [DMAG_W-1:0] r2_reg   [DIVN_W];
    logic [DMAG_W-1:0] r2_next  [DIVN_W];
    logic [DIVN_W-1:0] n2_reg   [DIVN_W];
    logic [DIVN_W-1:0] n2_next  [DIVN_W];

    always_comb
    begin
        logic [DMAG_W-1:0] ds;
        logic [DMAG_W-1:0] r1s;
        logic [DMAG_W-1:0] r2s;
        logic [DIVN_W-1:0] n1s;
        logic [DIVN_W-1:0] n2s;
        for (int k = 0; k < DIVN_W; k++)
        begin
            if (k == 0)
            begin
                ds           = in_den_reg;
                r1s          = '0;
                r2s          = '0;
                n1s          = in_n1_reg;
                n2s          = in_n2_reg;
                vld_next[k]  = in_vld_reg;
                meta_next[k] = in_meta_reg;
            end
            else
            begin
                ds           = den_reg[k-1];
                r1s          = r1_reg[k-1];
                r2s          = r2_reg[k-1];
                n1s          = n1_reg[k-1];
                n2s          = n2_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
                meta_next[k] = meta_reg[k-1];
            end
            {r1_next[k], n1_next[k]} = div_step(r1s, n1s, ds);
            {r2_next[k], n2_next[k]} = div_step(r2s, n2s, ds);
            den_next[k] = ds;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            vld_reg    <= '0;
        end
        else if (en)
        begin
            in_vld_reg <= in_valid;
            vld_reg    <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_meta_reg <= in_meta;
            in_n1_reg   <= in_num_one;
            in_n2_reg   <= in_num_two;
            in_den_reg  <= in_den;
            meta_reg    <= meta_next;
            den_reg     <= den_next;
            r1_reg      <= r1_next;
            n1_reg      <= n1_next;
            r2_reg      <= r2_next;
            n2_reg      <= n2_next;
        end
    end

    assign out_valid = vld_reg[DIVN_W-1];
    assign out_meta  = meta_reg[DIVN_W-1];
    assign out_q_one = n1_reg[DIVN_W-1];
    assign out_q_two = n2_reg[DIVN_W-1];

endmodule

@@ verif/qrs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver checker
// Watches the equation, root and threshold channels, predicts the roots of
// every accepted equation and compares each accepted root item field by field.
// ----------------------------------------------------------------------------
module qrs_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      eq_valid,
    input  logic                      eq_stall,
    input  qrs_pkg::qrs_in_t          eq_data,
    input  logic                      root_valid,
    input  logic                      root_stall,
    input  qrs_pkg::qrs_out_t         root_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [qrs_pkg::THR_W-1:0] cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        solved
);
    import qrs_pkg::*;

    qrs_out_t roots_due[$];
    logic [THR_W-1:0] thr;

    function automatic logic is_tiny(longint v, longint unsigned t);
        longint unsigned mag;
        mag = (v < 0) ? longint'(-v) : v;
        return (v == 0) || (mag < t);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned bit_w;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > x)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (x >= r + bit_w)
            begin
                x = x - (r + bit_w);
                r = (r >> 1) + bit_w;
            end
            else
                r = r >> 1;
            bit_w = bit_w >> 2;
        end
        return r;
    endfunction

    function automatic longint fix_div(longint num, longint den, inout logic ovf);
        longint q;
        q = (num * (longint'(1) << FRAC_BITS)) / den;
        if (q > 64'sd2147483647)
        begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (q < -64'sd2147483648)
        begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return q;
    endfunction

    function automatic qrs_out_t solve_roots(qrs_in_t eq, logic [THR_W-1:0] t16);
        longint a, b, c, r1, r2, d4, big;
        longint unsigned t, bb, rem, lim, sq, e, s;
        logic ovf, dz;
        logic [1:0] kind;
        qrs_out_t o;
        a = longint'(eq.coeff_a);
        b = longint'(eq.coeff_b);
        c = longint'(eq.coeff_c);
        t = t16;
        kind = KIND_NONE;
        r1 = 0;
        r2 = 0;
        ovf = 1'b0;
        if (is_tiny(a, t))
        begin
            if (is_tiny(b, t))
                kind = is_tiny(c, t) ? KIND_INF : KIND_NONE;
            else
            begin
                kind = KIND_ONE;
                r1 = fix_div(-c, b, ovf);
            end
        end
        else
        begin
            bb = b * b;
            d4 = longint'(bb >> 2) - a * c;
            rem = bb & 64'd3;
            lim = t << FRAC_BITS;
            big = longint'(1) << 42;
            if (d4 == 0 && rem == 0)
                dz = 1'b1;
            else if (d4 >= 0)
                dz = (d4 < big) && ((longint'(d4) * 4 + rem) < lim);
            else
                dz = (d4 > -big) && ((longint'(-d4) * 4 - rem) < lim);
            if (dz)
            begin
                kind = KIND_ONE;
                r1 = fix_div(-b, 2 * a, ovf);
                r2 = r1;
            end
            else if (d4 < 0)
                kind = KIND_NONE;
            else
            begin
                sq = floor_sqrt(d4);
                e = d4 - sq * sq;
                s = 2 * sq;
                if (e > sq || (e == sq && rem >= 1))
                    s = s + 1;
                kind = KIND_TWO;
                r1 = fix_div(-b + longint'(s), 2 * a, ovf);
                r2 = fix_div(-b - longint'(s), 2 * a, ovf);
            end
        end
        o.root_kind = kind;
        o.root_one = r1[31:0];
        o.root_two = r2[31:0];
        o.root_overflow = ovf;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr <= THR_RESET;
            errors <= 0;
            solved <= 0;
            pending <= 0;
            roots_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                thr <= cfg_data;
            if (eq_valid && !eq_stall)
                roots_due.push_back(solve_roots(eq_data, thr));
            if (root_valid && !root_stall)
            begin
                solved <= solved + 1;
                if (roots_due.size() == 0)
                begin
                    $display("%0t: unexpected root item, exp none act %h", $time, root_data);
                    errors <= errors + 1;
                end
                else
                begin
                    qrs_out_t x;
                    x = roots_due.pop_front();
                    if (x.root_kind !== root_data.root_kind)
                        $display("%0t: root_kind exp %0d act %0d", $time,
                                 x.root_kind, root_data.root_kind);
                    if (x.root_one !== root_data.root_one)
                        $display("%0t: root_one exp %h act %h", $time,
                                 x.root_one, root_data.root_one);
                    if (x.root_two !== root_data.root_two)
                        $display("%0t: root_two exp %h act %h", $time,
                                 x.root_two, root_data.root_two);
                    if (x.root_overflow !== root_data.root_overflow)
                        $display("%0t: root_overflow exp %0b act %0b", $time,
                                 x.root_overflow, root_data.root_overflow);
                    if (x !== root_data)
                        errors <= errors + 1;
                end
            end
            pending <= roots_due.size();
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives directed and random equations through several threshold settings
// with bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import qrs_pkg::*;

    localparam int DRAIN = 120;
    localparam int STUCK_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic eq_valid;
    logic eq_stall;
    qrs_in_t eq_data;
    logic root_valid;
    logic root_stall;
    qrs_out_t root_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [THR_W-1:0] cfg_data;
    int errors, pending, solved;
    int burst_left;
    int fed;
    int idle_cycles;
    logic hold_req;

    quadratic_root_solver_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .eq_valid   (eq_valid),
        .eq_stall   (eq_stall),
        .eq_data    (eq_data),
        .root_valid (root_valid),
        .root_stall (root_stall),
        .root_data  (root_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    qrs_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .eq_valid   (eq_valid),
        .eq_stall   (eq_stall),
        .eq_data    (eq_data),
        .root_valid (root_valid),
        .root_stall (root_stall),
        .root_data  (root_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending),
        .solved     (solved)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // output stall pattern, switching between four stall modes; long hold on request
    initial
    begin
        int mode, cnt, hold;
        root_stall = 1'b0;
        cnt = 0;
        mode = 0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold == 0)
                hold = 400;
            if (hold > 0)
            begin
                hold = hold - 1;
                root_stall <= 1'b1;
            end
            else
            begin
                if (cnt % 64 == 0)
                    mode = $urandom_range(0, 3);
                cnt = cnt + 1;
                case (mode)
                    0: root_stall <= 1'b0;
                    1: root_stall <= ($urandom_range(0, 3) == 0);
                    2: root_stall <= ($urandom_range(0, 3) != 0);
                    default: root_stall <= (cnt % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((eq_valid && !eq_stall) || (root_valid && !root_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STUCK_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_eq(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            repeat (gap)
            begin
                @(negedge clk);
                eq_valid <= 1'b0;
                eq_data <= {$urandom, $urandom, $urandom};
            end
        end
        @(negedge clk);
        eq_valid <= 1'b1;
        eq_data <= {a, b, c};
        @(posedge clk);
        while (eq_stall)
            @(posedge clk);
        burst_left = burst_left - 1;
        fed = fed + 1;
    endtask

    task automatic drain_pipe();
        @(negedge clk);
        eq_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_thr(logic [THR_W-1:0] v);
        drain_pipe();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coef(logic [15:0] t);
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: return $urandom;
            3: return $urandom_range(0, 1) ? 32'(t) : -32'(t);
            4: return 32'($urandom_range(0, 2 * t + 2)) * ($urandom_range(0, 1) ? 1 : -1);
            5: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff);
            6: return 32'd0;
            default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
        endcase
    endfunction

    task automatic random_eqs(int n, logic [15:0] t);
        int k, x, sel;
        logic [31:0] a, b, c;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 4);
            if (sel == 0)
            begin
                // repeated root: k(x - r)^2 with small integers
                k = $signed($urandom_range(1, 40)) * ($urandom_range(0, 1) ? 1 : -1);
                x = $signed($urandom_range(0, 60)) - 30;
                a = 32'(k) << 16;
                b = 32'(-2 * k * x) << 16;
                c = 32'(k * x * x) << 16;
            end
            else
            begin
                a = pick_coef(t);
                b = pick_coef(t);
                c = pick_coef(t);
            end
            push_eq(a, b, c);
        end
    endtask

    initial
    begin
        logic [15:0] thr_set [5];
        rst_n = 1'b0;
        eq_valid = 1'b0;
        eq_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_req = 1'b0;
        burst_left = 0;
        fed = 0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: linear cases, repeated, none, two, overflow, extremes
        push_eq(32'd0, 32'd0, 32'd0);
        push_eq(32'd0, 32'd0, 32'h0001_0000);
        push_eq(32'd0, 32'h0002_0000, 32'hfffc_0000);
        push_eq(32'd65, 32'd65, 32'd65);
        push_eq(32'd66, 32'h0001_0000, 32'd1);
        push_eq(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        push_eq(32'h0001_0000, 32'd0, 32'h0001_0000);
        push_eq(32'h0001_0000, 32'd0, 32'hffff_0000);
        push_eq(32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
        push_eq(32'h0001_0000, 32'd0, 32'd1);
        push_eq(32'd100, 32'h7fff_ffff, 32'd5);
        push_eq(32'd0, 32'd1, 32'h7fff_ffff);
        push_eq(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_eq(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_eq(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        push_eq(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        push_eq(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_eq(32'd1, 32'h8000_0000, 32'h7fff_ffff);
        push_eq(32'h0004_0000, 32'h0004_0000, 32'h0001_0000);
        push_eq(32'h0004_0000, 32'h0004_0001, 32'h0001_0000);
        random_eqs(150, THR_RESET);

        thr_set[0] = 16'd0;
        thr_set[1] = 16'hffff;
        thr_set[2] = 16'd66;
        thr_set[3] = $urandom;
        thr_set[4] = 16'd1;
        for (int p = 0; p < 5; p++)
        begin
            write_thr(thr_set[p]);
            if (p == 1)
            begin
                @(negedge clk);
                hold_req = 1'b1;
                push_eq(32'h0001_0000, 32'd0, 32'hffff_0000);
                hold_req = 1'b0;
            end
            push_eq(32'd0, 32'd0, 32'd0);
            push_eq(32'(thr_set[p]), 32'(thr_set[p]), 32'(thr_set[p]));
            push_eq(-32'(thr_set[p]), 32'h0001_0000, 32'd1);
            random_eqs(190, thr_set[p]);
        end
        drain_pipe();

        $display("Ran %0d equations, %0d root items checked, over six threshold settings",
                 fed, solved);
        $display("with zero and full-scale thresholds, bursty input and a long output hold.");
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
